[rtl/tbtk_pkg.sv]
// ----------------------------------------------------------------------------
// tbtk_pkg: shared types and constants for the trackball key-tap block
// Command format between front and back, config bundle, codes and states.
// ----------------------------------------------------------------------------
package tbtk_pkg;

   localparam int VALUE_W = 16;
   localparam int MAG_W   = VALUE_W + 1;   // magnitude of most negative delta
   localparam int THR_W   = 16;
   localparam int LIMIT_W = 4;
   localparam int KEY_W   = 8;
   localparam int KIND_W  = 2;
   localparam int AXIS_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int CMD_FIFO_DEPTH = 2;
   localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
   localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_FWD     = 2'd0,
      KIND_PRESS   = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   typedef enum logic [AXIS_W-1:0] {
      AXIS_X     = 2'd0,
      AXIS_Y     = 2'd1,
      AXIS_OTHER = 2'd2
   } axis_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_THRESHOLD = 3'd0,
      CSR_DEAD_BAND      = 3'd1,
      CSR_TAPS_LIMIT     = 3'd2,
      CSR_RIGHT_KEY      = 3'd3,
      CSR_LEFT_KEY       = 3'd4
   } csr_index_type;

   typedef enum logic {
      CMD_FWD  = 1'b0,   // emit one forwarded event
      CMD_MOVE = 1'b1    // accumulate X motion, tap, then forward zero
   } cmd_op_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_CHECK   = 2'd1,
      ST_RELEASE = 2'd2
   } back_state_type;

   typedef struct packed {
      logic [THR_W-1:0]   step_threshold;
      logic [THR_W-1:0]   dead_band;
      logic [LIMIT_W-1:0] taps_limit;
      logic [KEY_W-1:0]   right_key;
      logic [KEY_W-1:0]   left_key;
   } cfg_type;

   typedef struct packed {
      cmd_op_type                op;
      logic                      is_left;
      logic [MAG_W-1:0]          mag;
      logic                      fwd_relative;
      logic [AXIS_W-1:0]         fwd_axis;
      logic signed [VALUE_W-1:0] fwd_value;
   } cmd_type;

endpackage

[rtl/tbtk_if.sv]
// ----------------------------------------------------------------------------
// tbtk_if: request and response channel interfaces
// Valid/ready channels carrying motion requests and key-tap responses.
// ----------------------------------------------------------------------------
interface tbtk_req_if;
   logic              valid;
   logic              ready;
   logic              is_relative;
   logic [1:0]        axis;
   logic signed [15:0] move_value;

   modport source (output valid, output is_relative, output axis, output move_value,
                   input ready);
   modport sink   (input valid, input is_relative, input axis, input move_value,
                   output ready);
endinterface

interface tbtk_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [7:0]         key_code;
   logic               fwd_relative;
   logic [1:0]         fwd_axis;
   logic signed [15:0] fwd_value;
   logic               last;

   modport source (output valid, output kind, output key_code, output fwd_relative,
                   output fwd_axis, output fwd_value, output last, input ready);
   modport sink   (input valid, input kind, input key_code, input fwd_relative,
                   input fwd_axis, input fwd_value, input last, output ready);
endinterface

[rtl/trackball_motion_to_key_taps.sv]
// ----------------------------------------------------------------------------
// trackball_motion_to_key_taps: top level
// Turns relative X trackball motion into press/release key taps.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  req_bus | in  | valid/ready      | is_relative, axis, move_value
//  rsp_bus | out | valid/ready      | kind, key_code, fwd_relative, fwd_axis,
//          |     |                  | fwd_value, last
//  csr_*   | in  | csr_we (no wait) | csr_index, csr_wdata
//
//  Sequence: a forwarded request gives one response; an X motion request is
//  first added to its direction total, then gives a press and a release per
//  tap (taps <= taps_limit) and a closing consumed X event. The press /
//  release sequencer in tbtk_back runs these steps and stalls on rsp_bus.ready.
//  Reset: synchronous, active high; clears the queue, the sequencer, both
//  direction totals and the config registers to their defaults.
//  Stalls: a two-entry command queue lets requests be taken while responses
//  wait in the output register; rsp_bus.ready low only holds the sequencer.
// ----------------------------------------------------------------------------
module trackball_motion_to_key_taps
   import tbtk_pkg::*;
#(
   parameter int ACCUM_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   tbtk_req_if.sink              req_bus,
   tbtk_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // config registers
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_THRESHOLD: cfg_in.step_threshold = csr_wdata[THR_W-1:0];
            CSR_DEAD_BAND:      cfg_in.dead_band      = csr_wdata[THR_W-1:0];
            CSR_TAPS_LIMIT:     cfg_in.taps_limit     = csr_wdata[LIMIT_W-1:0];
            CSR_RIGHT_KEY:      cfg_in.right_key      = csr_wdata[KEY_W-1:0];
            CSR_LEFT_KEY:       cfg_in.left_key       = csr_wdata[KEY_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_threshold <= THR_W'(10);
         cfg_ff.dead_band      <= '0;
         cfg_ff.taps_limit     <= LIMIT_W'(3);
         cfg_ff.right_key      <= KEY_W'(43);
         cfg_ff.left_key       <= KEY_W'(225);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify requests into commands
   logic    push;
   cmd_type push_cmd;
   logic    fifo_full;

   tbtk_front u_front (
      .cfg       (cfg_ff),
      .fifo_full (fifo_full),
      .push      (push),
      .cmd       (push_cmd),
      .req       (req_bus)
   );

   // queue between classifier and sequencer
   logic    pop;
   cmd_type pop_cmd;
   logic    cmd_valid;

   tbtk_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (fifo_full),
      .pop       (pop),
      .pop_cmd   (pop_cmd),
      .not_empty (cmd_valid)
   );

   // back: totals, tap sequencing, response register
   tbtk_back #(
      .ACCUM_WIDTH (ACCUM_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (pop_cmd),
      .cmd_pop   (pop),
      .rsp       (rsp_bus)
   );

endmodule

[rtl/tbtk_front.sv]
// ----------------------------------------------------------------------------
// tbtk_front: request classifier
// Sorts each request into a plain forward or an X motion command.
// ----------------------------------------------------------------------------
module tbtk_front
   import tbtk_pkg::*;
(
   input  cfg_type       cfg,
   input  logic          fifo_full,
   output logic          push,
   output cmd_type       cmd,
   tbtk_req_if.sink      req
);

   logic [VALUE_W-1:0] raw;
   logic               negative;
   logic [MAG_W-1:0]   mag;
   logic               pass_through;
   logic               swallow;

   assign raw      = req.move_value;
   assign negative = raw[VALUE_W-1];
   assign mag      = negative ? (MAG_W'(1) << VALUE_W) - {1'b0, raw} : {1'b0, raw};

   // non-X/Y or non-relative events go out untouched
   assign pass_through = !req.is_relative || (req.axis != AXIS_X && req.axis != AXIS_Y);
   // Y events, and X inside the dead band, go out with value zero
   assign swallow = (req.axis == AXIS_Y) || (mag <= MAG_W'(cfg.dead_band));

   assign req.ready = !fifo_full;
   assign push      = req.valid && !fifo_full;

   always_comb begin
      cmd.is_left      = negative;
      cmd.mag          = mag;
      cmd.fwd_relative = req.is_relative;
      cmd.fwd_axis     = req.axis;
      cmd.fwd_value    = '0;
      if (pass_through) begin
         cmd.op        = CMD_FWD;
         cmd.fwd_value = req.move_value;
      end else if (swallow) begin
         cmd.op = CMD_FWD;
      end else begin
         cmd.op = CMD_MOVE;
      end
   end

endmodule

[rtl/tbtk_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// tbtk_cmd_fifo: command queue
// Short queue that decouples the classifier from the tap sequencer.
// ----------------------------------------------------------------------------
module tbtk_cmd_fifo
   import tbtk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    not_empty
);

   cmd_type                entry_ff [CMD_FIFO_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CMD_CNT_W'(CMD_FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   function automatic logic [CMD_PTR_W-1:0] ptr_next(input logic [CMD_PTR_W-1:0] p);
      if (p == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) return '0;
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CMD_CNT_W'(CMD_FIFO_DEPTH))
      else $error("cmd fifo count overflow");

   a_push_only_with_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full cmd fifo");

   a_pop_only_when_filled: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty cmd fifo");

endmodule

[rtl/tbtk_back.sv]
// ----------------------------------------------------------------------------
// tbtk_back: tap sequencer
// Holds the direction totals, emits press/release pairs and forwarded events.
// ----------------------------------------------------------------------------
module tbtk_back
   import tbtk_pkg::*;
#(
   parameter int ACCUM_WIDTH = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   tbtk_rsp_if.source rsp
);

   back_state_type          state_ff, state_in;
   logic [ACCUM_WIDTH-1:0]  right_ff, right_in;
   logic [ACCUM_WIDTH-1:0]  left_ff, left_in;
   logic                    is_left_ff, is_left_in;
   logic [LIMIT_W-1:0]      fires_ff, fires_in;
   logic                    out_valid_ff, out_valid_in;

   kind_type                kind_ff, kind_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic                    rel_ff, rel_in;
   logic [AXIS_W-1:0]       axis_ff, axis_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                    last_ff, last_in;
   logic                    emit;

   logic                    out_free;
   logic [ACCUM_WIDTH-1:0]  cur_total;
   logic [ACCUM_WIDTH-1:0]  thr_ext;
   logic                    tap_due;
   logic [ACCUM_WIDTH-1:0]  base_total;
   logic [ACCUM_WIDTH:0]    sum;
   logic [ACCUM_WIDTH-1:0]  sat_total;
   logic [KEY_W-1:0]        dir_key;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign cur_total = is_left_ff ? left_ff : right_ff;
   assign thr_ext   = ACCUM_WIDTH'(cfg.step_threshold);
   assign tap_due   = (cur_total >= thr_ext) && (fires_ff < cfg.taps_limit);
   assign dir_key   = is_left_ff ? cfg.left_key : cfg.right_key;

   assign base_total = cmd.is_left ? left_ff : right_ff;
   assign sum        = {1'b0, base_total} + (ACCUM_WIDTH+1)'(cmd.mag);
   assign sat_total  = sum[ACCUM_WIDTH] ? '1 : sum[ACCUM_WIDTH-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.op == CMD_MOVE) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (out_free) state_in = tap_due ? ST_RELEASE : ST_IDLE;
         end
         ST_RELEASE: begin
            if (out_free) state_in = ST_CHECK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and result selection
   always_comb begin
      cmd_pop    = 1'b0;
      emit       = 1'b0;
      right_in   = right_ff;
      left_in    = left_ff;
      is_left_in = is_left_ff;
      fires_in   = fires_ff;
      kind_in    = KIND_FWD;
      key_in     = '0;
      rel_in     = 1'b0;
      axis_in    = '0;
      value_in   = '0;
      last_in    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == CMD_FWD) begin
                  if (out_free) begin
                     cmd_pop  = 1'b1;
                     emit     = 1'b1;
                     rel_in   = cmd.fwd_relative;
                     axis_in  = cmd.fwd_axis;
                     value_in = cmd.fwd_value;
                     last_in  = 1'b1;
                  end
               end else begin
                  cmd_pop    = 1'b1;
                  is_left_in = cmd.is_left;
                  fires_in   = '0;
                  if (cmd.is_left) begin
                     left_in  = sat_total;
                     right_in = '0;
                  end else begin
                     right_in = sat_total;
                     left_in  = '0;
                  end
               end
            end
         end
         ST_CHECK: begin
            if (out_free) begin
               emit = 1'b1;
               if (tap_due) begin
                  kind_in = KIND_PRESS;
                  key_in  = dir_key;
               end else begin
                  // consumed X event closes the sequence
                  rel_in  = 1'b1;
                  axis_in = AXIS_X;
                  last_in = 1'b1;
               end
            end
         end
         ST_RELEASE: begin
            if (out_free) begin
               emit     = 1'b1;
               kind_in  = KIND_RELEASE;
               key_in   = dir_key;
               fires_in = fires_ff + 1'b1;
               if (is_left_ff) left_in  = left_ff - thr_ext;
               else            right_in = right_ff - thr_ext;
            end
         end
         default: ;
      endcase
      out_valid_in = emit ? 1'b1 : (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         right_ff     <= '0;
         left_ff      <= '0;
         is_left_ff   <= 1'b0;
         fires_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         right_ff     <= right_in;
         left_ff      <= left_in;
         is_left_ff   <= is_left_in;
         fires_ff     <= fires_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= kind_in;
         key_ff   <= key_in;
         rel_ff   <= rel_in;
         axis_ff  <= axis_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = kind_ff;
   assign rsp.key_code     = key_ff;
   assign rsp.fwd_relative = rel_ff;
   assign rsp.fwd_axis     = axis_ff;
   assign rsp.fwd_value    = value_ff;
   assign rsp.last         = last_ff;

   a_one_total_live: assert property (@(posedge clock) disable iff (reset)
      right_ff == '0 || left_ff == '0)
      else $error("both direction totals nonzero");

   a_release_after_press: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RELEASE |-> out_valid_ff && kind_ff == KIND_PRESS)
      else $error("release state without pending press");

   a_no_emit_over_held: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwrote an unaccepted response");

endmodule
